[hdl/three_body_invariant_mass_defines.svh]
// assertion macros for the three body invariant mass block
// used by the top level, needs clk_i and rst_ni in scope
`ifndef THREE_BODY_INVARIANT_MASS_DEFINES_SVH
`define THREE_BODY_INVARIANT_MASS_DEFINES_SVH

// same-cycle implication
`define TBIM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/tbim_pkg.sv]
// types, constants and the arctangent table of the invariant mass block
// no dependencies
`timescale 1ns / 1ps

package tbim_pkg;

  localparam int unsigned NUM_LANES    = 3;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned SQRT_STEPS   = 32;
  localparam int unsigned LANE_LAT     = 38;
  localparam int unsigned MERGE_LAT    = 38;
  localparam int unsigned PIPE_LAT     = LANE_LAT + MERGE_LAT;

  localparam logic signed [32:0] CORDIC_START_X = 33'sd652032874;
  localparam logic signed [15:0] COS_ONE        = 16'sd16384;
  localparam logic signed [15:0] COS_MINUS_ONE  = -16'sd16384;
  localparam logic signed [19:0] MASS_MAX       = 20'sd524287;

  typedef struct packed {
    logic        [15:0] momentum;
    logic signed [15:0] cos_polar;
    logic signed [15:0] azimuth;
    logic        [15:0] rest_mass;
  } particle_t;

  typedef struct packed {
    logic signed [26:0] px;
    logic signed [26:0] py;
    logic signed [26:0] pz;
    logic        [26:0] e;
  } fourvec_t;

  function automatic logic signed [32:0] atan_at(input logic [3:0] idx);
    logic signed [32:0] r;
    unique case (idx)
      4'd0:    r = 33'sh020000000;
      4'd1:    r = 33'sh012E4051D;
      4'd2:    r = 33'sh009FB385B;
      4'd3:    r = 33'sh0051111D4;
      4'd4:    r = 33'sh0028B0D43;
      4'd5:    r = 33'sh00145D7E1;
      4'd6:    r = 33'sh000A2F61E;
      4'd7:    r = 33'sh000517C55;
      4'd8:    r = 33'sh00028BE53;
      4'd9:    r = 33'sh000145F2F;
      4'd10:   r = 33'sh0000A2F98;
      4'd11:   r = 33'sh0000517CC;
      4'd12:   r = 33'sh000028BE6;
      4'd13:   r = 33'sh0000145F3;
      4'd14:   r = 33'sh00000A2F9;
      default: r = 33'sh00000517C;
    endcase
    return r;
  endfunction

endpackage

[hdl/tbim_sqrt.sv]
// pipelined floor square root, one result bit per stage
// depends on tbim_pkg
`timescale 1ns / 1ps

module tbim_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import tbim_pkg::*;

  logic [63:0] v_q [SQRT_STEPS];
  logic [63:0] r_q [SQRT_STEPS];
  logic [63:0] v_d [SQRT_STEPS];
  logic [63:0] r_d [SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      logic [63:0] vin;
      logic [63:0] rin;
      logic [63:0] bitv;
      logic [63:0] trial;
      vin   = (k == 0) ? rad_i : v_q[(k == 0) ? 0 : k - 1];
      rin   = (k == 0) ? 64'd0 : r_q[(k == 0) ? 0 : k - 1];
      bitv  = 64'd1 << (62 - 2 * k);
      trial = rin + bitv;
      if (vin >= trial) begin
        v_d[k] = vin - trial;
        r_d[k] = (rin >> 1) + bitv;
      end else begin
        v_d[k] = vin;
        r_d[k] = rin >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        v_q[k] <= v_d[k];
        r_q[k] <= r_d[k];
      end
    end
  end

  assign root_o = r_q[SQRT_STEPS-1][31:0];

endmodule

[hdl/tbim_cordic.sv]
// pipelined rotation cordic giving cos and sin of a 16-bit binary angle
// depends on tbim_pkg
`timescale 1ns / 1ps

module tbim_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] angle_i,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);
  import tbim_pkg::*;

  logic signed [32:0] x_q [CORDIC_STEPS+1];
  logic signed [32:0] y_q [CORDIC_STEPS+1];
  logic signed [32:0] z_q [CORDIC_STEPS+1];
  logic               flip_q [CORDIC_STEPS+1];

  logic signed [16:0] ang_ext;
  logic signed [16:0] ang_fold;
  logic               flip_d;

  always_comb begin
    ang_ext = {angle_i[15], angle_i};
    if (angle_i > COS_ONE) begin
      ang_fold = ang_ext - 17'sd32768;
      flip_d   = 1'b1;
    end else if (angle_i < COS_MINUS_ONE) begin
      ang_fold = ang_ext + 17'sd32768;
      flip_d   = 1'b1;
    end else begin
      ang_fold = ang_ext;
      flip_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_START_X;
      y_q[0]    <= '0;
      z_q[0]    <= {ang_fold, 16'd0};
      flip_q[0] <= flip_d;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][32]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_at(4'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_at(4'(i));
        end
      end
    end
  end

  assign cos_o = flip_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
  assign sin_o = flip_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];

endmodule

[hdl/tbim_lane.sv]
// one particle lane: cartesian momentum and energy in q.8 mev
// depends on tbim_pkg, tbim_sqrt, tbim_cordic
`timescale 1ns / 1ps

module tbim_lane (
  input  logic                clk_i,
  input  logic                en_i,
  input  tbim_pkg::particle_t part_i,
  output tbim_pkg::fourvec_t  fv_o
);
  import tbim_pkg::*;

  logic signed [15:0] c_clamp;
  logic        [15:0] p1_q;
  logic        [31:0] pp1_q;
  logic        [31:0] mm1_q;
  logic        [28:0] sarg1_q;
  logic signed [32:0] pc1_q;
  logic signed [31:0] csq;

  logic        [48:0] earg2_q;
  logic        [28:0] sarg2_q;
  logic        [32:0] pc_mag;
  logic        [26:0] pz_r;
  logic signed [26:0] pz_q [2:38];
  logic        [15:0] p_q [2:34];

  logic        [31:0] s_root;
  logic        [31:0] e_root;
  logic        [26:0] e_q [35:38];
  logic signed [32:0] cos_w;
  logic signed [32:0] sin_w;
  logic signed [32:0] co_q [18:35];
  logic signed [32:0] si_q [18:35];

  logic        [30:0] ps35_q;
  logic        [46:0] xlo_q;
  logic        [46:0] ylo_q;
  logic signed [48:0] xhi_q;
  logic signed [48:0] yhi_q;
  logic signed [64:0] prodx_q;
  logic signed [64:0] prody_q;
  logic signed [26:0] px_q;
  logic signed [26:0] py_q;

  always_comb begin
    if (part_i.cos_polar > COS_ONE) begin
      c_clamp = COS_ONE;
    end else if (part_i.cos_polar < COS_MINUS_ONE) begin
      c_clamp = COS_MINUS_ONE;
    end else begin
      c_clamp = part_i.cos_polar;
    end
    csq = c_clamp * c_clamp;
  end

  assign pc_mag = pc1_q[32] ? 33'(-pc1_q) : 33'(pc1_q);
  assign pz_r   = 27'((pc_mag + 33'd32) >> 6);

  function automatic logic signed [26:0] round36(input logic signed [64:0] v);
    logic [64:0] mag;
    logic [26:0] r;
    mag = v[64] ? 65'(-v) : 65'(v);
    r   = 27'((mag + (65'd1 << 35)) >> 36);
    return v[64] ? -$signed(r) : $signed(r);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= part_i.momentum;
      pp1_q   <= part_i.momentum * part_i.momentum;
      mm1_q   <= part_i.rest_mass * part_i.rest_mass;
      sarg1_q <= 29'(29'd268435456 - 29'(csq));
      pc1_q   <= $signed({17'd0, part_i.momentum}) * 33'(c_clamp);

      earg2_q <= {(33'(pp1_q) + 33'(mm1_q)), 16'd0};
      sarg2_q <= sarg1_q;
      pz_q[2] <= pc1_q[32] ? -$signed(pz_r) : $signed(pz_r);
      p_q[2]  <= p1_q;
      for (int k = 3; k <= 38; k++) pz_q[k] <= pz_q[k-1];
      for (int k = 3; k <= 34; k++) p_q[k] <= p_q[k-1];

      co_q[18] <= cos_w;
      si_q[18] <= sin_w;
      for (int k = 19; k <= 35; k++) begin
        co_q[k] <= co_q[k-1];
        si_q[k] <= si_q[k-1];
      end

      e_q[35] <= e_root[26:0];
      for (int k = 36; k <= 38; k++) e_q[k] <= e_q[k-1];

      ps35_q  <= p_q[34] * s_root[14:0];
      xlo_q   <= ps35_q * co_q[35][15:0];
      ylo_q   <= ps35_q * si_q[35][15:0];
      xhi_q   <= $signed({1'b0, ps35_q}) * $signed(co_q[35][32:16]);
      yhi_q   <= $signed({1'b0, ps35_q}) * $signed(si_q[35][32:16]);
      prodx_q <= ($signed(65'(xhi_q)) <<< 16) + $signed({18'd0, xlo_q});
      prody_q <= ($signed(65'(yhi_q)) <<< 16) + $signed({18'd0, ylo_q});
      px_q    <= round36(prodx_q);
      py_q    <= round36(prody_q);
    end
  end

  tbim_sqrt u_sqrt_sin (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  ({35'd0, sarg2_q}),
    .root_o (s_root)
  );

  tbim_sqrt u_sqrt_energy (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  ({15'd0, earg2_q}),
    .root_o (e_root)
  );

  tbim_cordic u_cordic (
    .clk_i   (clk_i),
    .en_i    (en_i),
    .angle_i (part_i.azimuth),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  assign fv_o.px = px_q;
  assign fv_o.py = py_q;
  assign fv_o.pz = pz_q[38];
  assign fv_o.e  = e_q[38];

endmodule

[hdl/tbim_merge.sv]
// sums the lane four-vectors and takes the signed root of the squared mass
// depends on tbim_pkg, tbim_sqrt
`timescale 1ns / 1ps

module tbim_merge (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  tbim_pkg::fourvec_t        fv_i [tbim_pkg::NUM_LANES],
  output logic signed        [19:0] mass_o
);
  import tbim_pkg::*;

  logic signed [26:0] sx_q;
  logic signed [26:0] sy_q;
  logic signed [26:0] sz_q;
  logic        [26:0] se_q;
  logic        [53:0] x2_q;
  logic        [53:0] y2_q;
  logic        [53:0] z2_q;
  logic        [53:0] e2_q;
  logic signed [55:0] a_q;
  logic        [55:0] b_q;
  logic signed [55:0] m2_q;
  logic        [55:0] mag_q;
  logic               neg_q [43:75];
  logic        [31:0] root;
  logic        [24:0] rounded;
  logic        [18:0] sat;
  logic signed [19:0] mass_q;

  always_comb begin
    rounded = 25'((33'(root) + 33'd128) >> 8);
    sat     = (rounded > 25'(MASS_MAX)) ? 19'(MASS_MAX) : rounded[18:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q  <= fv_i[0].px + fv_i[1].px + fv_i[2].px;
      sy_q  <= fv_i[0].py + fv_i[1].py + fv_i[2].py;
      sz_q  <= fv_i[0].pz + fv_i[1].pz + fv_i[2].pz;
      se_q  <= fv_i[0].e + fv_i[1].e + fv_i[2].e;
      x2_q  <= 54'(sx_q * sx_q);
      y2_q  <= 54'(sy_q * sy_q);
      z2_q  <= 54'(sz_q * sz_q);
      e2_q  <= se_q * se_q;
      a_q   <= $signed({2'd0, e2_q}) - $signed({2'd0, x2_q});
      b_q   <= 56'(y2_q) + 56'(z2_q);
      m2_q  <= a_q - $signed(b_q);
      mag_q <= m2_q[55] ? 56'(-m2_q) : 56'(m2_q);
      neg_q[43] <= m2_q[55];
      for (int k = 44; k <= 75; k++) neg_q[k] <= neg_q[k-1];
      mass_q <= neg_q[75] ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
    end
  end

  tbim_sqrt u_sqrt_mass (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .rad_i  ({8'd0, mag_q}),
    .root_o (root)
  );

  assign mass_o = mass_q;

endmodule

[hdl/three_body_invariant_mass.sv]
// invariant mass of three particles: input register, lanes, merge and output stage
// depends on tbim_pkg, tbim_lane, tbim_merge and the defines header
//
// usage: one request carries three particles (momentum, polar cosine, azimuth,
// rest mass); the result channel returns one signed invariant mass in mev.
// both channels are valid/ready; a request is taken when in_valid_i and
// in_ready_o are high, a result when out_valid_o and out_ready_i are high.
// a request passes the input register, the 38-stage particle lanes (cordic,
// two 32-stage square roots, multiplies) and the 38-stage merge (sums,
// squares, 32-stage square root, rounding); the three lanes run side by side.
// throughput is one request per cycle while the output does not stall.
// the whole pipeline advances together; when a result waits at the output and
// the receiver holds out_ready_i low, the pipeline freezes and in_ready_o drops.
// after reset the pipeline is empty and in_ready_o is high.
`timescale 1ns / 1ps
`include "three_body_invariant_mass_defines.svh"

module three_body_invariant_mass (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic        [15:0] first_momentum_i,
  input  logic signed [15:0] first_cos_polar_i,
  input  logic signed [15:0] first_azimuth_i,
  input  logic        [15:0] first_rest_mass_i,
  input  logic        [15:0] second_momentum_i,
  input  logic signed [15:0] second_cos_polar_i,
  input  logic signed [15:0] second_azimuth_i,
  input  logic        [15:0] second_rest_mass_i,
  input  logic        [15:0] third_momentum_i,
  input  logic signed [15:0] third_cos_polar_i,
  input  logic signed [15:0] third_azimuth_i,
  input  logic        [15:0] third_rest_mass_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [19:0] invariant_mass_o
);
  import tbim_pkg::*;

  logic                en;
  logic [PIPE_LAT:0]   vld_q;
  particle_t           part_q [NUM_LANES];
  fourvec_t            fv [NUM_LANES];

  assign en         = !vld_q[PIPE_LAT] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      part_q[0] <= '{first_momentum_i, first_cos_polar_i, first_azimuth_i,
                     first_rest_mass_i};
      part_q[1] <= '{second_momentum_i, second_cos_polar_i, second_azimuth_i,
                     second_rest_mass_i};
      part_q[2] <= '{third_momentum_i, third_cos_polar_i, third_azimuth_i,
                     third_rest_mass_i};
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tbim_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .part_i (part_q[g]),
      .fv_o   (fv[g])
    );
  end

  tbim_merge u_merge (
    .clk_i  (clk_i),
    .en_i   (en),
    .fv_i   (fv),
    .mass_o (invariant_mass_o)
  );

  assign out_valid_o = vld_q[PIPE_LAT];

  `TBIM_ASSERT_NOW(a_stall_only_when_full, !in_ready_o, out_valid_o,
    "input stalled without a waiting result")
  `TBIM_ASSERT_NEXT(a_frozen_on_stall, !in_ready_o, vld_q == $past(vld_q),
    "pipeline moved during a stall")
  `TBIM_ASSERT_NOW(a_mass_range, out_valid_o, invariant_mass_o != -20'sd524288,
    "mass outside its symmetric range")

endmodule
